### rtl/core/key_event_fifo_chord_detect_top_assert.svh
// Assertion helpers for the key event queue.
`ifndef KEY_EVENT_FIFO_CHORD_DETECT_TOP_ASSERT_SVH
`define KEY_EVENT_FIFO_CHORD_DETECT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define KEFCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("kefcd assertion failed");

// Checked at every edge, reset included.
`define KEFCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kefcd assertion failed");

`else

`define KEFCD_ASSERT(lbl, clk, rstn, prop)
`define KEFCD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/kefcd_pkg.sv
`default_nettype none

package kefcd_pkg;

  localparam int DEPTH   = 128;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int KEY_W   = 2;
  localparam int TIME_W  = 24;
  localparam int ENTRY_W = KEY_W + TIME_W;
  localparam int WIN_W   = 8;
  localparam int GAP_W   = TIME_W + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CHORD_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_LENGTH   = 2'd1;

  localparam logic [WIN_W-1:0]  CHORD_WINDOW_RST = 8'd20;
  localparam logic [TIME_W-1:0] DAY_LENGTH_RST   = 24'd8640000;

  localparam logic [KEY_W-1:0] KEY_BOTH = 2'b11;

  // result codes
  localparam logic [1:0] RC_STORED  = 2'd0;
  localparam logic [1:0] RC_DROPPED = 2'd1;
  localparam logic [1:0] RC_EMPTY   = 2'd2;
  localparam logic [1:0] RC_KEY     = 2'd3;

  // key codes
  localparam logic [1:0] KC_NEXT = 2'd0;
  localparam logic [1:0] KC_UP   = 2'd1;
  localparam logic [1:0] KC_QUIT = 2'd2;

  localparam logic [1:0] CONSUMED_NONE = 2'd0;
  localparam logic [1:0] CONSUMED_ONE  = 2'd1;
  localparam logic [1:0] CONSUMED_TWO  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [KEY_W-1:0]  key_bits;
    logic [TIME_W-1:0] event_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [1:0] key_code;
    logic [1:0] consumed;
  } out_rsp_t;

  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD_A = 4'b0010,
    S_RD_B = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/kefcd_store.sv
`default_nettype none

module kefcd_store
  import kefcd_pkg::*;
(
  input  wire                clk_i,
  input  mem_req_t           req_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // single port, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end else begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/key_event_fifo_chord_detect_top.sv
`default_nettype none
// Channel   Dir  Handshake                 Payload
// in        in   in_valid_i / in_stall_o   in_req_i  (cmd, key_bits, event_time)
// out       out  out_valid_o / out_stall_i out_rsp_o (result_code, key_code, consumed)
// cfg       in   cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// A push or an empty pop is answered from idle; a pop with entries reads the
// first in S_RD_A and, with two or more, the second in S_RD_B, set by the
// single port event store (one read per cycle, data registered).
// Reset clears both pointers and loads the register defaults; the store
// itself is not cleared, so no clearing pass.
// A stalled output holds its result; the next request is still taken and its
// result parks until the output register frees up.

module key_event_fifo_chord_detect_top
  import kefcd_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output out_rsp_t              out_rsp_o,
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "key_event_fifo_chord_detect_top_assert.svh"

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rp_q, rp_d;
  logic [WIN_W-1:0]   win_q;
  logic [TIME_W-1:0]  day_q;
  logic [ENTRY_W-1:0] first_q, first_d;
  out_rsp_t           pend_q, pend_d;
  out_rsp_t           out_q, out_d;
  logic               out_valid_q, out_valid_d;

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;

  logic               in_fire;
  logic               out_free;
  logic               res_vld;
  out_rsp_t           res;
  logic [PTR_W-1:0]   sec_ptr;
  logic [TIME_W-1:0]  ta, tb;
  logic [GAP_W-1:0]   gap;
  logic               chord;

  kefcd_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sec_ptr    = ptr_next(rp_q);

  // chord check: first entry latched, second on the read port
  assign ta    = first_q[ENTRY_W-1:KEY_W];
  assign tb    = rdata[ENTRY_W-1:KEY_W];
  // wrap through the day length; a negative gap lands far above any window
  assign gap   = {2'b00, tb} - {2'b00, ta} + ((tb < ta) ? {2'b00, day_q} : '0);
  assign chord = ((first_q[KEY_W-1:0] | rdata[KEY_W-1:0]) == KEY_BOTH) &&
                 (gap <= GAP_W'(win_q));

  always_comb begin
    state_d       = state_q;
    wp_d          = wp_q;
    rp_d          = rp_q;
    first_d       = first_q;
    pend_d        = pend_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    res_vld       = 1'b0;
    res           = '0;
    mem_req.we    = 1'b0;
    mem_req.addr  = rp_q;
    mem_req.wdata = {in_req_i.event_time, in_req_i.key_bits};

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_req_i.cmd) begin
            res_vld = 1'b1;
            if (ptr_next(wp_q) == rp_q) begin
              res.result_code = RC_DROPPED;
            end else begin
              mem_req.we      = 1'b1;
              mem_req.addr    = wp_q;
              wp_d            = ptr_next(wp_q);
              res.result_code = RC_STORED;
            end
          end else if (rp_q == wp_q) begin
            res_vld         = 1'b1;
            res.result_code = RC_EMPTY;
          end else begin
            mem_req.addr = rp_q;
            state_d      = S_RD_A;
          end
        end
      end
      S_RD_A: begin
        first_d = rdata;
        if (sec_ptr != wp_q) begin
          mem_req.addr = sec_ptr;
          state_d      = S_RD_B;
        end else begin
          // lone entry: give it right away
          res_vld         = 1'b1;
          res.result_code = RC_KEY;
          res.key_code    = rdata[0] ? KC_UP : KC_NEXT;
          res.consumed    = CONSUMED_ONE;
          rp_d            = sec_ptr;
        end
      end
      S_RD_B: begin
        res_vld         = 1'b1;
        res.result_code = RC_KEY;
        if (chord) begin
          res.key_code = KC_QUIT;
          res.consumed = CONSUMED_TWO;
          rp_d         = ptr_next(sec_ptr);
        end else begin
          res.key_code = first_q[0] ? KC_UP : KC_NEXT;
          res.consumed = CONSUMED_ONE;
          rp_d         = sec_ptr;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register; a result that finds it busy waits in pend_q
    if (res_vld) begin
      pend_d  = res;
      state_d = out_free ? S_IDLE : S_DONE;
    end

    if (res_vld && out_free) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (state_q == S_DONE && out_free) begin
      out_d       = pend_q;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
      win_q       <= CHORD_WINDOW_RST;
      day_q       <= DAY_LENGTH_RST;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_CHORD_WINDOW: win_q <= cfg_wdata_i[WIN_W-1:0];
          CFG_DAY_LENGTH:   day_q <= cfg_wdata_i[TIME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // a stored push advances the write pointer by exactly one slot
  `KEFCD_ASSERT(a_push_adv, clk_i, rst_ni, (in_fire && !in_req_i.cmd && (ptr_next(wp_q) != rp_q)) |=> (wp_q == $past(ptr_next(wp_q))))
  // entries are consumed only by key results
  `KEFCD_ASSERT(a_consume, clk_i, rst_ni, out_valid_o |-> ((out_rsp_o.result_code == RC_KEY) == (out_rsp_o.consumed != CONSUMED_NONE)))
  // a quit chord always removes two entries
  `KEFCD_ASSERT(a_quit_two, clk_i, rst_ni, (out_valid_o && (out_rsp_o.key_code == KC_QUIT)) |-> (out_rsp_o.consumed == CONSUMED_TWO))
  // the store is written only on a push accepted in idle
  `KEFCD_ASSERT(a_wr_idle, clk_i, rst_ni, mem_req.we |-> (in_fire && !in_req_i.cmd))
  // once reset is seen at an edge, no result is offered in the next cycle
  `KEFCD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

`default_nettype wire
